### rtl/hfcc_pkg.sv
// Shared types, constants and the CRC-8 function for the humidity frame checker.
package hfcc_pkg;

   localparam int DataWidth     = 8;
   localparam int RawWidth      = 16;
   localparam int CentiWidth    = 14;
   localparam int ScaleWidth    = 14;
   localparam int ProductWidth  = RawWidth + ScaleWidth;
   localparam int ReqTdataWidth = 8;
   localparam int RspTdataWidth = 16;

   localparam logic [7:0]            CrcPoly     = 8'h31;
   localparam logic [RawWidth-1:0]   RawMask     = 16'hFFFC;
   localparam logic [ScaleWidth-1:0] ScaleNum    = 14'd12500;
   localparam logic [CentiWidth-1:0] OffsetCenti = 14'd600;
   localparam logic [CentiWidth-1:0] FullScale   = 14'd10000;

   // Byte position codes
   localparam logic [1:0] PosHigh  = 2'd0;
   localparam logic [1:0] PosLow   = 2'd1;
   localparam logic [1:0] PosCheck = 2'd2;

   // Status codes
   localparam logic StatusGood  = 1'b0;
   localparam logic StatusCrcBad = 1'b1;

   // One completed reply handed from the frame tracker to the converter
   typedef struct packed {
      logic                valid;
      logic [RawWidth-1:0] raw;
      logic                crc_ok;
   } frame_type;

   // Scaled value after the multiply stage
   typedef struct packed {
      logic                  valid;
      logic [CentiWidth-1:0] scaled;
      logic                  crc_ok;
   } scaled_type;

   // CRC-8, polynomial 0x31, MSB first, eight bit steps unrolled
   function automatic logic [7:0] crc_absorb(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/humidity_frame_check_convert_top.sv
// Top level of the humidity reply checker and converter.
//
//   channel | direction | tdata                     | tuser
//   req     | in        | [7:0] data_byte           | frame_start
//   rsp     | out       | [13:0] humidity_centi     | status
//
// One byte is taken per cycle, every cycle while the result side is not stalled.
// A reply's result moves from the tracker register, which loads on the edge that takes
// its checksum byte, to the multiply register and then to the result register.
// Synchronous reset clears byte position, CRC and all stage valid bits.
// A stalled result holds the whole pipeline; req_tready follows rsp_tready then.
module humidity_frame_check_convert_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [hfcc_pkg::ReqTdataWidth-1:0]   req_tdata,   // [7:0] data_byte
   input  logic                                 req_tuser,   // [0] frame_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [hfcc_pkg::RspTdataWidth-1:0]   rsp_tdata,   // [13:0] humidity_centi, [15:14] 0
   output logic                                 rsp_tuser    // [0] status
);
   import hfcc_pkg::*;

   logic                  advance;
   logic                  byte_accept;
   frame_type             frame;
   logic [CentiWidth-1:0] humidity_centi;

   // Pipeline moves whenever the result register is empty or being taken
   assign advance     = !rsp_tvalid || rsp_tready;
   assign req_tready  = advance;
   assign byte_accept = req_tvalid && advance;

   hfcc_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .byte_accept (byte_accept),
      .data_byte   (req_tdata[DataWidth-1:0]),
      .frame_start (req_tuser),
      .frame       (frame)
   );

   hfcc_convert u_convert (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .frame          (frame),
      .result_valid   (rsp_tvalid),
      .humidity_centi (humidity_centi),
      .status         (rsp_tuser)
   );

   assign rsp_tdata = {{(RspTdataWidth-CentiWidth){1'b0}}, humidity_centi};

endmodule

### rtl/hfcc_frame.sv
// Byte position tracking, running CRC and capture of a finished reply.
module hfcc_frame (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              byte_accept,
   input  logic [hfcc_pkg::DataWidth-1:0]    data_byte,
   input  logic                              frame_start,
   output hfcc_pkg::frame_type               frame
);
   import hfcc_pkg::*;

   logic [1:0]           byte_position_ff, byte_position_in;
   logic [7:0]           running_crc_ff, running_crc_in;
   logic [DataWidth-1:0] high_byte_ff, high_byte_in;
   logic [DataWidth-1:0] low_byte_ff, low_byte_in;
   frame_type            frame_ff, frame_in;
   logic [1:0]           pos;

   // Next state of the reply tracker
   always_comb begin
      pos              = frame_start ? PosHigh : byte_position_ff;
      byte_position_in = byte_position_ff;
      running_crc_in   = running_crc_ff;
      high_byte_in     = high_byte_ff;
      low_byte_in      = low_byte_ff;
      frame_in         = frame_ff;
      if (advance) begin
         frame_in.valid = 1'b0;
      end
      if (byte_accept) begin
         case (pos)
            PosLow: begin
               low_byte_in      = data_byte;
               running_crc_in   = crc_absorb(running_crc_ff, data_byte);
               byte_position_in = PosCheck;
            end
            PosCheck: begin
               frame_in.valid   = 1'b1;
               frame_in.raw     = {high_byte_ff, low_byte_ff} & RawMask;
               frame_in.crc_ok  = (data_byte == running_crc_ff);
               running_crc_in   = 8'd0;
               byte_position_in = PosHigh;
            end
            default: begin
               // high byte, also taken for the unused position
               high_byte_in     = data_byte;
               running_crc_in   = crc_absorb(8'd0, data_byte);
               byte_position_in = PosLow;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= PosHigh;
         running_crc_ff   <= 8'd0;
         high_byte_ff     <= '0;
         low_byte_ff      <= '0;
         frame_ff.valid   <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         running_crc_ff   <= running_crc_in;
         high_byte_ff     <= high_byte_in;
         low_byte_ff      <= low_byte_in;
         frame_ff.valid   <= frame_in.valid;
      end
      frame_ff.raw    <= frame_in.raw;
      frame_ff.crc_ok <= frame_in.crc_ok;
   end

   assign frame = frame_ff;

endmodule

### rtl/hfcc_convert.sv
// Scale multiply, offset removal and saturation into the result register.
module hfcc_convert (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  hfcc_pkg::frame_type                 frame,
   output logic                                result_valid,
   output logic [hfcc_pkg::CentiWidth-1:0]     humidity_centi,
   output logic                                status
);
   import hfcc_pkg::*;

   scaled_type              scaled_ff, scaled_in;
   logic [ProductWidth-1:0] product;
   logic                    result_valid_ff, result_valid_in;
   logic [CentiWidth-1:0]   humidity_ff, humidity_in;
   logic                    status_ff, status_in;
   logic [CentiWidth-1:0]   above_offset;

   // Multiply stage: (12500 * raw) >> 16
   always_comb begin
      product   = {{ScaleWidth{1'b0}}, frame.raw} * {{RawWidth{1'b0}}, ScaleNum};
      scaled_in = scaled_ff;
      if (advance) begin
         scaled_in.valid  = frame.valid;
         scaled_in.scaled = product[ProductWidth-1 -: CentiWidth];
         scaled_in.crc_ok = frame.crc_ok;
      end
   end

   // Offset and saturation stage
   always_comb begin
      above_offset    = scaled_ff.scaled - OffsetCenti;
      result_valid_in = result_valid_ff;
      humidity_in     = humidity_ff;
      status_in       = status_ff;
      if (advance) begin
         result_valid_in = scaled_ff.valid;
         if (!scaled_ff.crc_ok) begin
            humidity_in = '0;
            status_in   = StatusCrcBad;
         end else begin
            status_in = StatusGood;
            if (scaled_ff.scaled < OffsetCenti) begin
               humidity_in = '0;
            end else if (above_offset > FullScale) begin
               humidity_in = FullScale;
            end else begin
               humidity_in = above_offset;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scaled_ff.valid <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         scaled_ff.valid <= scaled_in.valid;
         result_valid_ff <= result_valid_in;
      end
      scaled_ff.scaled <= scaled_in.scaled;
      scaled_ff.crc_ok <= scaled_in.crc_ok;
      humidity_ff      <= humidity_in;
      status_ff        <= status_in;
   end

   assign result_valid   = result_valid_ff;
   assign humidity_centi = humidity_ff;
   assign status         = status_ff;

endmodule
